>>> hdl/i2cm_pkg.sv
package i2cm_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned BIT_CNT_W = 4;

    localparam logic [BYTE_W-1:0] ACK_WAIT_RESET = 8'd255;

    localparam logic MODE_COMMAND = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BUS_BUSY = 2'd1;
    localparam logic [1:0] ST_NO_ACK   = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_S0, PH_S1, PH_S2,
        PH_P0, PH_P1, PH_P2,
        PH_W0, PH_W1, PH_W2,
        PH_A0, PH_A1, PH_AW,
        PH_R0, PH_R1, PH_R2, PH_R3,
        PH_K0, PH_K1, PH_K2
    } t_phase;

    typedef struct packed {
        logic              mode;
        logic [1:0]        command;
        logic [BYTE_W-1:0] write_data;
        logic              send_ack;
        logic              sda_in;
        logic              scl_in;
    } t_item;

    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy_res;
        logic              done_res;
        logic [1:0]        status;
        logic [BYTE_W-1:0] read_data;
    } t_result;

endpackage

>>> hdl/i2cm_in_reg.sv
module i2cm_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  i2cm_pkg::t_item i_item,
    input  logic            i_down_ready,
    output logic            o_step,
    output i2cm_pkg::t_item o_item
);

    logic            r_valid;
    logic            n_valid;
    i2cm_pkg::t_item r_item;
    logic            accept;

    always_comb begin
        o_step  = r_valid && i_down_ready;
        o_stall = r_valid && !i_down_ready;
        accept  = i_valid && !o_stall;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_step) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_item = r_item;

endmodule

>>> hdl/i2cm_core.sv
module i2cm_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  i2cm_pkg::t_item               i_item,
    input  logic [i2cm_pkg::BYTE_W-1:0]   i_ack_wait_limit,
    output i2cm_pkg::t_result             o_result
);

    i2cm_pkg::t_phase                   r_phase, n_phase;
    logic [i2cm_pkg::BIT_CNT_W-1:0]     r_bit_count, n_bit_count;
    logic [i2cm_pkg::BYTE_W-1:0]        r_shift, n_shift;
    logic [i2cm_pkg::BYTE_W-1:0]        r_wait, n_wait;
    logic                               r_ack_choice, n_ack_choice;
    logic                               r_clock_drive, n_clock_drive;
    logic                               r_data_drive, n_data_drive;
    logic [i2cm_pkg::BYTE_W-1:0]        r_last_read, n_last_read;
    logic                               done;
    logic [1:0]                         status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= i2cm_pkg::PH_IDLE;
            r_bit_count   <= '0;
            r_shift       <= '0;
            r_wait        <= '0;
            r_ack_choice  <= 1'b0;
            r_clock_drive <= 1'b1;
            r_data_drive  <= 1'b1;
            r_last_read   <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_bit_count   <= n_bit_count;
            r_shift       <= n_shift;
            r_wait        <= n_wait;
            r_ack_choice  <= n_ack_choice;
            r_clock_drive <= n_clock_drive;
            r_data_drive  <= n_data_drive;
            r_last_read   <= n_last_read;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_bit_count   = r_bit_count;
        n_shift       = r_shift;
        n_wait        = r_wait;
        n_ack_choice  = r_ack_choice;
        n_clock_drive = r_clock_drive;
        n_data_drive  = r_data_drive;
        n_last_read   = r_last_read;
        done          = 1'b0;
        status        = i2cm_pkg::ST_OK;

        if (i_item.mode == i2cm_pkg::MODE_COMMAND) begin
            if (r_phase != i2cm_pkg::PH_IDLE) begin
                done   = 1'b1;
                status = i2cm_pkg::ST_REJECTED;
            end else begin
                n_bit_count = '0;
                n_wait      = '0;
                unique case (i_item.command)
                    i2cm_pkg::CMD_START: begin
                        // A start needs both lines released high.
                        if (!i_item.sda_in || !i_item.scl_in) begin
                            done   = 1'b1;
                            status = i2cm_pkg::ST_BUS_BUSY;
                        end else begin
                            n_phase = i2cm_pkg::PH_S0;
                        end
                    end
                    i2cm_pkg::CMD_STOP: begin
                        n_phase = i2cm_pkg::PH_P0;
                    end
                    i2cm_pkg::CMD_WRITE: begin
                        n_shift = i_item.write_data;
                        n_phase = i2cm_pkg::PH_W0;
                    end
                    default: begin
                        n_shift      = '0;
                        n_ack_choice = i_item.send_ack;
                        n_phase      = i2cm_pkg::PH_R0;
                    end
                endcase
            end
        end else begin
            unique case (r_phase)
                i2cm_pkg::PH_S0: begin
                    n_data_drive  = 1'b1;
                    n_clock_drive = 1'b1;
                    n_phase       = i2cm_pkg::PH_S1;
                end
                i2cm_pkg::PH_S1: begin
                    n_data_drive = 1'b0;
                    n_phase      = i2cm_pkg::PH_S2;
                end
                i2cm_pkg::PH_S2: begin
                    n_clock_drive = 1'b0;
                    n_phase       = i2cm_pkg::PH_IDLE;
                    done          = 1'b1;
                end
                i2cm_pkg::PH_P0: begin
                    n_clock_drive = 1'b0;
                    n_data_drive  = 1'b0;
                    n_phase       = i2cm_pkg::PH_P1;
                end
                i2cm_pkg::PH_P1: begin
                    n_clock_drive = 1'b1;
                    n_phase       = i2cm_pkg::PH_P2;
                end
                i2cm_pkg::PH_P2: begin
                    n_data_drive = 1'b1;
                    n_phase      = i2cm_pkg::PH_IDLE;
                    done         = 1'b1;
                end
                i2cm_pkg::PH_W0: begin
                    n_clock_drive = 1'b0;
                    n_phase       = i2cm_pkg::PH_W1;
                end
                i2cm_pkg::PH_W1: begin
                    n_data_drive = r_shift[i2cm_pkg::BYTE_W-1];
                    n_shift      = {r_shift[i2cm_pkg::BYTE_W-2:0], 1'b0};
                    n_phase      = i2cm_pkg::PH_W2;
                end
                i2cm_pkg::PH_W2: begin
                    n_clock_drive = 1'b1;
                    n_bit_count   = r_bit_count + 1'b1;
                    n_phase       = (n_bit_count >= i2cm_pkg::BITS_PER_BYTE)
                                    ? i2cm_pkg::PH_A0 : i2cm_pkg::PH_W0;
                end
                i2cm_pkg::PH_A0: begin
                    n_clock_drive = 1'b0;
                    n_data_drive  = 1'b1;
                    n_phase       = i2cm_pkg::PH_A1;
                end
                i2cm_pkg::PH_A1: begin
                    n_clock_drive = 1'b1;
                    n_wait        = '0;
                    n_phase       = i2cm_pkg::PH_AW;
                end
                i2cm_pkg::PH_AW: begin
                    // SCL stays high until SDA is low or the wait runs out.
                    if (i_item.sda_in && (r_wait < i_ack_wait_limit)) begin
                        n_wait = r_wait + 1'b1;
                    end else begin
                        n_clock_drive = 1'b0;
                        n_phase       = i2cm_pkg::PH_IDLE;
                        done          = 1'b1;
                        status        = i_item.sda_in ? i2cm_pkg::ST_NO_ACK
                                                      : i2cm_pkg::ST_OK;
                    end
                end
                i2cm_pkg::PH_R0: begin
                    n_data_drive = 1'b1;
                    n_bit_count  = '0;
                    n_phase      = i2cm_pkg::PH_R1;
                end
                i2cm_pkg::PH_R1: begin
                    n_clock_drive = 1'b0;
                    n_phase       = i2cm_pkg::PH_R2;
                end
                i2cm_pkg::PH_R2: begin
                    n_clock_drive = 1'b1;
                    n_phase       = i2cm_pkg::PH_R3;
                end
                i2cm_pkg::PH_R3: begin
                    n_shift     = {r_shift[i2cm_pkg::BYTE_W-2:0], i_item.sda_in};
                    n_bit_count = r_bit_count + 1'b1;
                    n_phase     = (n_bit_count >= i2cm_pkg::BITS_PER_BYTE)
                                  ? i2cm_pkg::PH_K0 : i2cm_pkg::PH_R1;
                end
                i2cm_pkg::PH_K0: begin
                    n_clock_drive = 1'b0;
                    n_data_drive  = !r_ack_choice;
                    n_phase       = i2cm_pkg::PH_K1;
                end
                i2cm_pkg::PH_K1: begin
                    n_clock_drive = 1'b1;
                    n_phase       = i2cm_pkg::PH_K2;
                end
                i2cm_pkg::PH_K2: begin
                    n_clock_drive = 1'b0;
                    n_data_drive  = 1'b1;
                    n_last_read   = r_shift;
                    n_phase       = i2cm_pkg::PH_IDLE;
                    done          = 1'b1;
                end
                default: begin
                    n_phase = i2cm_pkg::PH_IDLE;
                end
            endcase
        end

        o_result.scl_out   = n_clock_drive;
        o_result.sda_out   = n_data_drive;
        o_result.busy_res  = (n_phase != i2cm_pkg::PH_IDLE);
        o_result.done_res  = done;
        o_result.status    = status;
        o_result.read_data = n_last_read;
    end

endmodule

>>> hdl/i2cm_out_reg.sv
module i2cm_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  i2cm_pkg::t_result i_result,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_stall,
    output i2cm_pkg::t_result o_result
);

    logic              r_valid;
    i2cm_pkg::t_result r_result;

    assign o_ready  = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

>>> hdl/i2c_master_bit_engine.sv
// Open-drain I2C master byte engine. Each input transaction is either a command
// (start, stop, write byte with acknowledge wait, read byte ending in ACK/NACK)
// or one delay tick that advances the SCL/SDA pin sequence; every input
// transaction yields exactly one result transaction with the line drives,
// busy/done flags, status and the last received byte. An input register feeds
// the sequencer logic, whose result lands in an output register, and the
// sustained rate is one transaction per clock while the result side is not
// stalled. The acknowledge wait limit may be written only while no transaction
// is in flight.
module i2c_master_bit_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [i2cm_pkg::BYTE_W-1:0] i_cfg_data,

    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_mode,
    input  logic [1:0]                  i_command,
    input  logic [i2cm_pkg::BYTE_W-1:0] i_write_data,
    input  logic                        i_send_ack,
    input  logic                        i_sda_in,
    input  logic                        i_scl_in,

    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_scl_out,
    output logic                        o_sda_out,
    output logic                        o_busy_res,
    output logic                        o_done_res,
    output logic [1:0]                  o_status,
    output logic [i2cm_pkg::BYTE_W-1:0] o_read_data
);

    logic [i2cm_pkg::BYTE_W-1:0] r_ack_wait_limit;
    i2cm_pkg::t_item             in_item;
    i2cm_pkg::t_item             core_item;
    i2cm_pkg::t_result           core_result;
    i2cm_pkg::t_result           out_result;
    logic                        step;
    logic                        out_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_wait_limit <= i2cm_pkg::ACK_WAIT_RESET;
        end else if (i_cfg_valid) begin
            r_ack_wait_limit <= i_cfg_data;
        end
    end

    always_comb begin
        in_item.mode       = i_mode;
        in_item.command    = i_command;
        in_item.write_data = i_write_data;
        in_item.send_ack   = i_send_ack;
        in_item.sda_in     = i_sda_in;
        in_item.scl_in     = i_scl_in;
    end

    i2cm_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_item       (in_item),
        .i_down_ready (out_ready),
        .o_step       (step),
        .o_item       (core_item)
    );

    i2cm_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_item           (core_item),
        .i_ack_wait_limit (r_ack_wait_limit),
        .o_result         (core_result)
    );

    i2cm_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (core_result),
        .o_ready  (out_ready),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    assign o_scl_out   = out_result.scl_out;
    assign o_sda_out   = out_result.sda_out;
    assign o_busy_res  = out_result.busy_res;
    assign o_done_res  = out_result.done_res;
    assign o_status    = out_result.status;
    assign o_read_data = out_result.read_data;

endmodule
